[hw/rtl/sns_pkg.sv]
// shared types and constants of the step sequencer note scheduler
package sns_pkg;

   localparam int STEP_COUNT_DEF   = 64;
   localparam int ENTRIES_DEF      = 64;
   localparam int LAYER_COUNT_DEF  = 4;
   localparam int OFF_SLOTS_DEF    = 16;
   localparam int MAX_OUT          = 64;
   localparam int CFG_COUNT        = 4;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_STOP = 2'd2;

   localparam logic KIND_ON  = 1'b0;
   localparam logic KIND_OFF = 1'b1;

   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] layer_sel;
      logic [5:0] entry_index;
      logic       entry_valid;
      logic [5:0] entry_step;
      logic [3:0] entry_channel;
      logic [6:0] entry_note;
      logic [6:0] entry_velocity;
      logic [6:0] entry_length;
   } req_type;

   typedef struct packed {
      logic       event_kind;
      logic [3:0] out_channel;
      logic [6:0] out_note;
      logic [6:0] out_velocity;
      logic       last_event;
      logic       events_dropped;
   } rsp_type;

   typedef struct packed {
      logic [1:0] index;
      logic [5:0] data;
   } csr_type;

   // buffered event: kind, channel, note, velocity
   typedef struct packed {
      logic       kind;
      logic [3:0] chan;
      logic [6:0] note;
      logic [6:0] vel;
   } event_type;

endpackage

[hw/rtl/sns_ifs.sv]
// valid/ready channel interfaces of the note scheduler
interface sns_req_if import sns_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sns_rsp_if import sns_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sns_csr_if import sns_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/step_sequencer_note_scheduler.sv]
// step sequencer note scheduler top level
//
//  channel  dir  payload                      transfer when
//  req_ch   in   req_type (mode, entry ...)   req_ch.valid && req_ch.ready
//  rsp_ch   out  rsp_type (event ...)         rsp_ch.valid && rsp_ch.ready
//  csr_ch   in   csr_type (index, data)       csr_ch.valid (ready tied high)
//
// a load or an unused mode is done while idle; a tick checks each queued note-off, scans
// table entries layer by layer, reducing (step+length) modulo STEP_COUNT per queued note,
// then sends each result, waiting on rsp_ch.ready; all of it paced by the single
// read port of the note table, the note-off queue and the result buffer.
// one item at a time: req_ch.ready is low during a tick or stop and its results.
// reset is synchronous; no clearing pass is needed.
module step_sequencer_note_scheduler import sns_pkg::*; #(
   parameter int STEP_COUNT        = STEP_COUNT_DEF,
   parameter int ENTRIES_PER_LAYER = ENTRIES_DEF,
   parameter int LAYER_COUNT       = LAYER_COUNT_DEF,
   parameter int OFF_SLOTS         = OFF_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sns_req_if.sink    req_ch,
   sns_rsp_if.source  rsp_ch,
   sns_csr_if.sink    csr_ch
);
   localparam int SW   = $clog2(STEP_COUNT);
   localparam int CW   = (SW > 6) ? SW : 6;
   localparam int SUMW = ((SW > 7) ? SW : 7) + 1;
   localparam int LW   = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
   localparam int LCW  = $clog2(LAYER_COUNT + 1);
   localparam int PW   = ($clog2(ENTRIES_PER_LAYER) + 1 > 6) ?
                         $clog2(ENTRIES_PER_LAYER) + 1 : 6;
   localparam int TD   = LAYER_COUNT * ENTRIES_PER_LAYER;
   localparam int TAW  = $clog2(TD);
   localparam int OW   = (OFF_SLOTS > 1) ? $clog2(OFF_SLOTS) : 1;
   localparam int OCW  = $clog2(OFF_SLOTS + 1);
   localparam int OFFW = SW + 11;
   localparam int RAW  = $clog2(MAX_OUT);
   localparam int RW   = $clog2(MAX_OUT + 1);
   localparam int EW   = $bits(event_type);

   typedef enum logic [3:0] {
      S_IDLE, S_OFF_RD, S_OFF_CHK, S_LAY_START, S_SCAN_RD, S_SCAN_CHK,
      S_MOD, S_ADV, S_DR_RD, S_DR_LOAD, S_DR_WAIT
   } state_type;

   state_type        state_ff;
   logic             stop_ff;
   logic [SW-1:0]    step_ff;
   logic [OCW-1:0]   cnt_ff;
   logic [OCW-1:0]   idx_ff;
   logic [OCW-1:0]   wr_ff;
   logic [LCW-1:0]   lay_ff;
   logic [PW-1:0]    pos_ff;
   logic [PW-1:0]    scan_pos_ff [LAYER_COUNT];
   logic [5:0]       first_ff [CFG_COUNT];
   logic [RW-1:0]    nout_ff;
   logic             drop_ff;
   logic [RAW-1:0]   rd_ff;
   logic [SUMW-1:0]  sum_ff;
   logic [3:0]       ochan_ff;
   logic [6:0]       onote_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   // memories
   logic             tbl_we;
   logic [TAW-1:0]   tbl_waddr, tbl_raddr;
   logic [31:0]      tbl_wdata, tbl_rdata;
   logic             pend_we;
   logic [OW-1:0]    pend_waddr;
   logic [OFFW-1:0]  pend_wdata, pend_rdata;
   logic             buf_we;
   event_type        emit_ev;
   logic [EW-1:0]    buf_rdata;

   // decoded read data
   logic             e_valid;
   logic [5:0]       e_step;
   logic [3:0]       e_chan;
   logic [6:0]       e_note, e_vel, e_len;
   logic [SW-1:0]    p_step;
   logic [3:0]       p_chan;
   logic [6:0]       p_note;
   logic             off_hit, match_on, req_xfer, load_ok;
   logic [PW:0]      pos_nx;
   logic             pos_end;
   event_type        buf_ev;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   assign {e_valid, e_step, e_chan, e_note, e_vel, e_len} = tbl_rdata;
   assign {p_step, p_chan, p_note} = pend_rdata;
   assign buf_ev = event_type'(buf_rdata);

   assign load_ok = (32'(req_ch.data.layer_sel) < LAYER_COUNT) &&
                    (32'(req_ch.data.entry_index) < ENTRIES_PER_LAYER);

   assign off_hit  = (state_ff == S_OFF_CHK) && (stop_ff || p_step == step_ff);
   assign match_on = (state_ff == S_SCAN_CHK) && e_valid &&
                     (CW'(e_step) == CW'(step_ff));
   assign pos_nx   = {1'b0, pos_ff} + 1'b1;
   assign pos_end  = (pos_nx == (PW+1)'(ENTRIES_PER_LAYER));

   always_comb begin
      tbl_we    = req_xfer && req_ch.data.mode == MODE_LOAD && load_ok;
      tbl_waddr = TAW'(req_ch.data.layer_sel) * TAW'(ENTRIES_PER_LAYER)
                  + TAW'(req_ch.data.entry_index);
      tbl_wdata = {req_ch.data.entry_valid, req_ch.data.entry_step,
                   req_ch.data.entry_channel, req_ch.data.entry_note,
                   req_ch.data.entry_velocity, req_ch.data.entry_length};
      tbl_raddr = TAW'(lay_ff[LW-1:0]) * TAW'(ENTRIES_PER_LAYER) + TAW'(pos_ff);

      pend_we    = 1'b0;
      pend_waddr = wr_ff[OW-1:0];
      pend_wdata = pend_rdata;
      if (state_ff == S_OFF_CHK && !off_hit) begin
         pend_we = 1'b1;
      end else if (state_ff == S_MOD && sum_ff < SUMW'(STEP_COUNT)) begin
         pend_we    = 1'b1;
         pend_waddr = cnt_ff[OW-1:0];
         pend_wdata = {sum_ff[SW-1:0], ochan_ff, onote_ff};
      end

      if (off_hit) begin
         emit_ev = '{kind: KIND_OFF, chan: p_chan, note: p_note, vel: 7'd0};
      end else begin
         emit_ev = '{kind: KIND_ON, chan: e_chan, note: e_note, vel: e_vel};
      end
      buf_we = (off_hit || match_on) && nout_ff < RW'(MAX_OUT);
   end

   sns_ram #(.WIDTH(32), .DEPTH(TD)) u_note_tbl (
      .clock(clock), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
      .raddr(tbl_raddr), .rdata_ff(tbl_rdata)
   );

   sns_ram #(.WIDTH(OFFW), .DEPTH(OFF_SLOTS)) u_off_list (
      .clock(clock), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
      .raddr(idx_ff[OW-1:0]), .rdata_ff(pend_rdata)
   );

   sns_ram #(.WIDTH(EW), .DEPTH(MAX_OUT)) u_evt_buf (
      .clock(clock), .we(buf_we), .waddr(nout_ff[RAW-1:0]), .wdata(emit_ev),
      .raddr(rd_ff), .rdata_ff(buf_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stop_ff      <= 1'b0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         wr_ff        <= '0;
         lay_ff       <= '0;
         pos_ff       <= '0;
         nout_ff      <= '0;
         drop_ff      <= 1'b0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < LAYER_COUNT; l++) begin
            scan_pos_ff[l] <= '0;
         end
         for (int c = 0; c < CFG_COUNT; c++) begin
            first_ff[c] <= '0;
         end
      end else begin
         if (csr_ch.valid) begin
            first_ff[csr_ch.data.index] <= csr_ch.data.data;
         end
         if (off_hit || match_on) begin
            if (nout_ff < RW'(MAX_OUT)) begin
               nout_ff <= nout_ff + 1'b1;
            end else begin
               drop_ff <= 1'b1;
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer && (req_ch.data.mode == MODE_TICK ||
                                req_ch.data.mode == MODE_STOP)) begin
                  stop_ff  <= (req_ch.data.mode == MODE_STOP);
                  nout_ff  <= '0;
                  drop_ff  <= 1'b0;
                  idx_ff   <= '0;
                  wr_ff    <= '0;
                  state_ff <= S_OFF_RD;
               end
            end
            S_OFF_RD: begin
               if (idx_ff == cnt_ff) begin
                  if (stop_ff) begin
                     cnt_ff  <= '0;
                     step_ff <= '0;
                     for (int l = 0; l < LAYER_COUNT; l++) begin
                        scan_pos_ff[l] <= (l < CFG_COUNT) ? PW'(first_ff[l]) : '0;
                     end
                     rd_ff    <= '0;
                     state_ff <= (cnt_ff == '0) ? S_IDLE : S_DR_RD;
                  end else begin
                     cnt_ff   <= wr_ff;
                     lay_ff   <= '0;
                     state_ff <= S_LAY_START;
                  end
               end else begin
                  state_ff <= S_OFF_CHK;
               end
            end
            S_OFF_CHK: begin
               if (!off_hit) begin
                  wr_ff <= wr_ff + 1'b1;
               end
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_OFF_RD;
            end
            S_LAY_START: begin
               if (lay_ff == LCW'(LAYER_COUNT)) begin
                  state_ff <= S_ADV;
               end else if (scan_pos_ff[lay_ff[LW-1:0]] >= PW'(ENTRIES_PER_LAYER)) begin
                  lay_ff <= lay_ff + 1'b1;
               end else begin
                  pos_ff   <= scan_pos_ff[lay_ff[LW-1:0]];
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
               if (!match_on) begin
                  scan_pos_ff[lay_ff[LW-1:0]] <= pos_ff;
                  lay_ff   <= lay_ff + 1'b1;
                  state_ff <= S_LAY_START;
               end else if (cnt_ff < OCW'(OFF_SLOTS)) begin
                  ochan_ff <= e_chan;
                  onote_ff <= e_note;
                  sum_ff   <= SUMW'(step_ff) + SUMW'(e_len);
                  state_ff <= S_MOD;
               end else if (pos_end) begin
                  lay_ff   <= lay_ff + 1'b1;
                  state_ff <= S_LAY_START;
               end else begin
                  pos_ff   <= pos_nx[PW-1:0];
                  state_ff <= S_SCAN_RD;
               end
            end
            S_MOD: begin
               // reduce modulo the step count one subtraction a cycle
               if (sum_ff >= SUMW'(STEP_COUNT)) begin
                  sum_ff <= sum_ff - SUMW'(STEP_COUNT);
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (pos_end) begin
                     lay_ff   <= lay_ff + 1'b1;
                     state_ff <= S_LAY_START;
                  end else begin
                     pos_ff   <= pos_nx[PW-1:0];
                     state_ff <= S_SCAN_RD;
                  end
               end
            end
            S_ADV: begin
               if ((SW+1)'(step_ff) + 1'b1 == (SW+1)'(STEP_COUNT)) begin
                  step_ff <= '0;
                  for (int l = 0; l < LAYER_COUNT; l++) begin
                     scan_pos_ff[l] <= (l < CFG_COUNT) ? PW'(first_ff[l]) : '0;
                  end
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
               rd_ff    <= '0;
               state_ff <= (nout_ff == '0) ? S_IDLE : S_DR_RD;
            end
            S_DR_RD: begin
               state_ff <= S_DR_LOAD;
            end
            S_DR_LOAD: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= '{event_kind: buf_ev.kind, out_channel: buf_ev.chan,
                                 out_note: buf_ev.note, out_velocity: buf_ev.vel,
                                 last_event: (RW'(rd_ff) + 1'b1 == nout_ff),
                                 events_dropped: drop_ff};
               state_ff     <= S_DR_WAIT;
            end
            S_DR_WAIT: begin
               if (rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_data_ff.last_event) begin
                     state_ff <= S_IDLE;
                  end else begin
                     rd_ff    <= rd_ff + 1'b1;
                     state_ff <= S_DR_RD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule

[hw/rtl/sns_ram.sv]
// simple dual port ram, one write and one registered read port
module sns_ram import sns_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule

[hw/rtl/sns_checker.sv]
// port level checks of the note scheduler and their bind
module sns_checker import sns_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_mode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_last
);
   // a pending result holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // no new item while results are still going out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item accepted during result drain");

   // the last result ends the item
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("block busy after last result");

   // a load gives no result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_LOAD |=> !rsp_valid && req_ready)
      else $error("load produced a result");
endmodule

bind step_sequencer_note_scheduler sns_checker u_sns_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .req_mode(req_ch.data.mode),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_last(rsp_ch.data.last_event)
);
